// ----- rtl/sme_pkg.sv -----
package sme_pkg;

   localparam int DATA_W            = 32;
   localparam int PC_W              = 24;
   localparam int OP_W              = 8;
   localparam int IMM_W             = 24;
   localparam int STACK_DEPTH_DEF   = 1024;
   localparam int GLOBAL_DEPTH_DEF  = 256;

   typedef enum logic [2:0] {
      ST_RUN   = 3'd0,
      ST_HALT  = 3'd1,
      ST_DIVZ  = 3'd2,
      ST_OVER  = 3'd3,
      ST_UNDER = 3'd4,
      ST_BADG  = 3'd5
   } status_type;

   localparam logic [OP_W-1:0] OP_HALT  = 8'd0;
   localparam logic [OP_W-1:0] OP_PUSHC = 8'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 8'd2;
   localparam logic [OP_W-1:0] OP_SUB   = 8'd3;
   localparam logic [OP_W-1:0] OP_MUL   = 8'd4;
   localparam logic [OP_W-1:0] OP_DIV   = 8'd5;
   localparam logic [OP_W-1:0] OP_MOD   = 8'd6;
   localparam logic [OP_W-1:0] OP_RDINT = 8'd7;
   localparam logic [OP_W-1:0] OP_WRINT = 8'd8;
   localparam logic [OP_W-1:0] OP_RDCHR = 8'd9;
   localparam logic [OP_W-1:0] OP_WRCHR = 8'd10;
   localparam logic [OP_W-1:0] OP_PUSHG = 8'd11;
   localparam logic [OP_W-1:0] OP_POPG  = 8'd12;
   localparam logic [OP_W-1:0] OP_ASF   = 8'd13;
   localparam logic [OP_W-1:0] OP_RSF   = 8'd14;
   localparam logic [OP_W-1:0] OP_PUSHL = 8'd15;
   localparam logic [OP_W-1:0] OP_POPL  = 8'd16;
   localparam logic [OP_W-1:0] OP_EQ    = 8'd17;
   localparam logic [OP_W-1:0] OP_NE    = 8'd18;
   localparam logic [OP_W-1:0] OP_LT    = 8'd19;
   localparam logic [OP_W-1:0] OP_LE    = 8'd20;
   localparam logic [OP_W-1:0] OP_GT    = 8'd21;
   localparam logic [OP_W-1:0] OP_GE    = 8'd22;
   localparam logic [OP_W-1:0] OP_JMP   = 8'd23;
   localparam logic [OP_W-1:0] OP_BRF   = 8'd24;
   localparam logic [OP_W-1:0] OP_BRT   = 8'd25;
   localparam logic [OP_W-1:0] OP_CALL  = 8'd26;
   localparam logic [OP_W-1:0] OP_RET   = 8'd27;
   localparam logic [OP_W-1:0] OP_DROP  = 8'd28;
   localparam logic [OP_W-1:0] OP_PUSHR = 8'd29;
   localparam logic [OP_W-1:0] OP_POPR  = 8'd30;
   localparam logic [OP_W-1:0] OP_DUP   = 8'd31;

endpackage

// ----- rtl/sme_if.sv -----
interface sme_req_if;
   import sme_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [IMM_W-1:0]         immediate;
   logic signed [DATA_W-1:0] read_value;

   modport source (output valid, op, immediate, read_value, input ready);
   modport sink   (input valid, op, immediate, read_value, output ready);
endinterface

interface sme_rsp_if;
   import sme_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [PC_W-1:0]          next_pc;
   logic                     write_valid;
   logic                     write_is_char;
   logic signed [DATA_W-1:0] write_value;
   logic [2:0]               status;

   modport source (output valid, next_pc, write_valid, write_is_char, write_value, status,
                   input ready);
   modport sink   (input valid, next_pc, write_valid, write_is_char, write_value, status,
                   output ready);
endinterface

// ----- rtl/stack_machine_execute.sv -----
// An accepted word passes through check, up to two stack reads and execute,
// then waits in the response state; div and mod also wait in the
// one-bit-per-cycle divider. A fault answers from check or the first read, a stopped machine straight from idle.
// One word at a time; the next word can be taken in the cycle after the result
// is taken.
// Synchronous reset clears pc, stack and frame pointers, return register and
// status; stack and globals memories are not cleared.
module stack_machine_execute #(
   parameter int STACK_DEPTH  = sme_pkg::STACK_DEPTH_DEF,
   parameter int GLOBAL_DEPTH = sme_pkg::GLOBAL_DEPTH_DEF
) (
   input logic     clock,
   input logic     reset,
   sme_req_if.sink   req_chan,
   sme_rsp_if.source rsp_chan
);
   import sme_pkg::*;

   localparam int SW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int GW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;
   localparam int CW = ((SW > IMM_W) ? SW : IMM_W) + 3;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_RD1, S_RD2, S_DIV, S_EXEC, S_RESP
   } state_type;

   state_type         state_ff;
   logic [OP_W-1:0]   op_ff;
   logic [IMM_W-1:0]  imm_ff;
   logic [DATA_W-1:0] rv_ff;
   logic [PC_W-1:0]   pc_ff;
   logic [SW-1:0]     sp_ff;
   logic [SW-1:0]     fp_ff;
   logic [DATA_W-1:0] ret_ff;
   status_type        run_status_ff;
   logic [DATA_W-1:0] opa_ff;
   logic [DATA_W-1:0] opb_ff;
   logic [AW-1:0]     laddr_ff;
   logic [PC_W-1:0]   rsp_pc_ff;
   logic              rsp_wv_ff;
   logic              rsp_wc_ff;
   logic [DATA_W-1:0] rsp_wval_ff;
   status_type        rsp_st_ff;

   logic [PC_W-1:0]   pc1;
   logic [CW-1:0]     pops;
   logic [CW-1:0]     pushes;
   logic [CW-1:0]     sp_w;
   logic signed [CW-1:0] laddr;
   logic              is_binary;
   logic              is_divmod;
   logic              needs_read;
   status_type        chk_err;
   logic              fault_hit;
   status_type        fault_code;

   logic              stk_we;
   logic [AW-1:0]     stk_wr_addr;
   logic [DATA_W-1:0] stk_wr_data;
   logic [AW-1:0]     stk_rd_addr;
   logic [DATA_W-1:0] stk_rd_data;
   logic              glb_we;
   logic [DATA_W-1:0] glb_rd_data;

   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quot;
   logic [DATA_W-1:0] div_rem;
   logic [DATA_W-1:0] alu_res;
   logic [DATA_W-1:0] prod;
   logic [PC_W-1:0]   exec_pc;
   logic [SW-1:0]     sp_m1;
   logic [SW-1:0]     sp_m2;
   logic [SW-1:0]     sp_p1;

   assign pc1   = pc_ff + 1'b1;
   assign sp_w  = CW'(sp_ff);
   assign sp_m1 = sp_ff - 1'b1;
   assign sp_m2 = sp_ff - SW'(2);
   assign sp_p1 = sp_ff + 1'b1;
   assign laddr = $signed(CW'(fp_ff))
                + $signed({{(CW - IMM_W){imm_ff[IMM_W-1]}}, imm_ff});

   assign is_divmod = (op_ff == OP_DIV) || (op_ff == OP_MOD);
   assign is_binary = ((op_ff >= OP_ADD) && (op_ff <= OP_MOD))
                   || ((op_ff >= OP_EQ) && (op_ff <= OP_GE));

   always_comb begin
      pops       = '0;
      pushes     = '0;
      needs_read = 1'b0;
      unique case (op_ff)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
         OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
            pops = CW'(2); pushes = CW'(1); needs_read = 1'b1;
         end
         OP_PUSHC, OP_RDINT, OP_RDCHR, OP_CALL, OP_PUSHR: begin
            pushes = CW'(1);
         end
         OP_PUSHG, OP_PUSHL: begin
            pushes = CW'(1); needs_read = 1'b1;
         end
         OP_WRINT, OP_WRCHR, OP_POPG, OP_POPL, OP_BRF, OP_BRT, OP_RET, OP_POPR: begin
            pops = CW'(1); needs_read = 1'b1;
         end
         OP_DUP: begin
            pops = CW'(1); pushes = CW'(2); needs_read = 1'b1;
         end
         OP_ASF:  pushes = CW'(1) + CW'(imm_ff);
         OP_DROP: pops = CW'(imm_ff);
         OP_RSF:  needs_read = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      chk_err = ST_RUN;
      priority if (op_ff == OP_RSF) begin
         if (fp_ff == '0) chk_err = ST_UNDER;
      end else if (pops > sp_w) begin
         chk_err = ST_UNDER;
      end else if ((sp_w - pops + pushes) > CW'(STACK_DEPTH)) begin
         chk_err = ST_OVER;
      end else if (((op_ff == OP_PUSHG) || (op_ff == OP_POPG))
                   && (CW'(imm_ff) >= CW'(GLOBAL_DEPTH))) begin
         chk_err = ST_BADG;
      end else if ((op_ff == OP_PUSHL) || (op_ff == OP_POPL)) begin
         if (laddr < 0) chk_err = ST_UNDER;
         else if (laddr >= $signed(CW'(STACK_DEPTH))) chk_err = ST_OVER;
      end else begin
         chk_err = ST_RUN;
      end
   end

   // faults detected before any state changes
   always_comb begin
      fault_hit  = 1'b0;
      fault_code = ST_RUN;
      if (state_ff == S_CHECK && chk_err != ST_RUN) begin
         fault_hit  = 1'b1;
         fault_code = chk_err;
      end else if (state_ff == S_RD1) begin
         if (is_divmod && stk_rd_data == '0) begin
            fault_hit  = 1'b1;
            fault_code = ST_DIVZ;
         end else if (op_ff == OP_RSF && stk_rd_data > DATA_W'(STACK_DEPTH)) begin
            fault_hit  = 1'b1;
            fault_code = ST_OVER;
         end
      end
   end

   always_comb begin
      priority if (state_ff == S_RD1) stk_rd_addr = sp_m2[AW-1:0];
      else if (op_ff == OP_RSF)       stk_rd_addr = AW'(fp_ff - 1'b1);
      else if (op_ff == OP_PUSHL)     stk_rd_addr = laddr[AW-1:0];
      else                            stk_rd_addr = sp_m1[AW-1:0];
   end

   assign prod = opa_ff * opb_ff;

   always_comb begin
      unique case (op_ff)
         OP_ADD:  alu_res = opa_ff + opb_ff;
         OP_SUB:  alu_res = opa_ff - opb_ff;
         OP_MUL:  alu_res = prod;
         OP_DIV:  alu_res = div_quot;
         OP_MOD:  alu_res = div_rem;
         OP_EQ:   alu_res = DATA_W'(opa_ff == opb_ff);
         OP_NE:   alu_res = DATA_W'(opa_ff != opb_ff);
         OP_LT:   alu_res = DATA_W'($signed(opa_ff) < $signed(opb_ff));
         OP_LE:   alu_res = DATA_W'($signed(opa_ff) <= $signed(opb_ff));
         OP_GT:   alu_res = DATA_W'($signed(opa_ff) > $signed(opb_ff));
         OP_GE:   alu_res = DATA_W'($signed(opa_ff) >= $signed(opb_ff));
         default: alu_res = '0;
      endcase
   end

   always_comb begin
      stk_we      = 1'b0;
      stk_wr_addr = sp_ff[AW-1:0];
      stk_wr_data = opb_ff;
      if (state_ff == S_EXEC) begin
         unique case (op_ff)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: begin
               stk_we = 1'b1; stk_wr_addr = sp_m2[AW-1:0]; stk_wr_data = alu_res;
            end
            OP_PUSHC: begin
               stk_we = 1'b1;
               stk_wr_data = {{(DATA_W - IMM_W){imm_ff[IMM_W-1]}}, imm_ff};
            end
            OP_RDINT, OP_RDCHR: begin
               stk_we = 1'b1; stk_wr_data = rv_ff;
            end
            OP_PUSHG, OP_PUSHL, OP_DUP: stk_we = 1'b1;
            OP_CALL: begin
               stk_we = 1'b1; stk_wr_data = DATA_W'(pc1);
            end
            OP_PUSHR: begin
               stk_we = 1'b1; stk_wr_data = ret_ff;
            end
            OP_ASF: begin
               stk_we = 1'b1; stk_wr_data = DATA_W'(fp_ff);
            end
            OP_POPL: begin
               stk_we = 1'b1; stk_wr_addr = laddr_ff;
            end
            default: ;
         endcase
      end
   end

   assign glb_we = (state_ff == S_EXEC) && (op_ff == OP_POPG);

   always_comb begin
      unique case (op_ff)
         OP_JMP, OP_CALL: exec_pc = imm_ff;
         OP_BRF:  exec_pc = (opb_ff == '0) ? imm_ff : pc1;
         OP_BRT:  exec_pc = (opb_ff != '0) ? imm_ff : pc1;
         OP_RET:  exec_pc = opb_ff[PC_W-1:0];
         default: exec_pc = pc1;
      endcase
   end

   assign div_start = (state_ff == S_RD2) && is_divmod;

   sme_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   sme_ram #(.WIDTH(DATA_W), .DEPTH(GLOBAL_DEPTH)) u_glob_ram (
      .clock   (clock),
      .wr_en   (glb_we),
      .wr_addr (imm_ff[GW-1:0]),
      .wr_data (opb_ff),
      .rd_addr (imm_ff[GW-1:0]),
      .rd_data (glb_rd_data)
   );

   sme_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (stk_rd_data),
      .divisor   (opb_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pc_ff         <= '0;
         sp_ff         <= '0;
         fp_ff         <= '0;
         ret_ff        <= '0;
         run_status_ff <= ST_RUN;
      end else if (fault_hit) begin
         run_status_ff <= fault_code;
         pc_ff         <= pc1;
         rsp_pc_ff     <= pc1;
         rsp_st_ff     <= fault_code;
         rsp_wv_ff     <= 1'b0;
         rsp_wc_ff     <= 1'b0;
         rsp_wval_ff   <= '0;
         state_ff      <= S_RESP;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  op_ff  <= req_chan.op;
                  imm_ff <= req_chan.immediate;
                  rv_ff  <= req_chan.read_value;
                  if (run_status_ff != ST_RUN) begin
                     // stopped: report and change nothing
                     rsp_pc_ff   <= pc_ff;
                     rsp_st_ff   <= run_status_ff;
                     rsp_wv_ff   <= 1'b0;
                     rsp_wc_ff   <= 1'b0;
                     rsp_wval_ff <= '0;
                     state_ff    <= S_RESP;
                  end else begin
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_CHECK: begin
               laddr_ff <= laddr[AW-1:0];
               state_ff <= needs_read ? S_RD1 : S_EXEC;
            end
            S_RD1: begin
               opb_ff   <= (op_ff == OP_PUSHG) ? glb_rd_data : stk_rd_data;
               state_ff <= is_binary ? S_RD2 : S_EXEC;
            end
            S_RD2: begin
               opa_ff   <= stk_rd_data;
               state_ff <= is_divmod ? S_DIV : S_EXEC;
            end
            S_DIV: begin
               if (div_done) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               pc_ff       <= exec_pc;
               rsp_pc_ff   <= exec_pc;
               rsp_st_ff   <= (op_ff == OP_HALT) ? ST_HALT : ST_RUN;
               rsp_wv_ff   <= (op_ff == OP_WRINT) || (op_ff == OP_WRCHR);
               rsp_wc_ff   <= (op_ff == OP_WRCHR);
               rsp_wval_ff <= ((op_ff == OP_WRINT) || (op_ff == OP_WRCHR)) ? opb_ff : '0;
               if (op_ff == OP_HALT) run_status_ff <= ST_HALT;
               unique case (op_ff)
                  OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
                  OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE,
                  OP_WRINT, OP_WRCHR, OP_POPG, OP_POPL, OP_BRF, OP_BRT, OP_RET:
                     sp_ff <= sp_m1;
                  OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHG, OP_PUSHL,
                  OP_CALL, OP_PUSHR, OP_DUP:
                     sp_ff <= sp_p1;
                  OP_POPR: begin
                     sp_ff  <= sp_m1;
                     ret_ff <= opb_ff;
                  end
                  OP_ASF: begin
                     fp_ff <= sp_p1;
                     sp_ff <= SW'(sp_w + CW'(1) + CW'(imm_ff));
                  end
                  OP_RSF: begin
                     sp_ff <= fp_ff - 1'b1;
                     fp_ff <= opb_ff[SW-1:0];
                  end
                  OP_DROP: sp_ff <= SW'(sp_w - CW'(imm_ff));
                  default: ;
               endcase
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_chan.ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = (state_ff == S_RESP);
   assign rsp_chan.next_pc       = rsp_pc_ff;
   assign rsp_chan.write_valid   = rsp_wv_ff;
   assign rsp_chan.write_is_char = rsp_wc_ff;
   assign rsp_chan.write_value   = rsp_wval_ff;
   assign rsp_chan.status        = rsp_st_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid)) else $error("accepting while a word is pending");
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
   a_stopped_holds: assert property (@(posedge clock) disable iff (reset)
      (run_status_ff != ST_RUN) |=> (run_status_ff == $past(run_status_ff)))
      else $error("stopped machine changed status");
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV)) else $error("divider finished outside div state");
endmodule

// ----- rtl/sme_ram.sv -----
module sme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/sme_div.sv -----
module sme_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [sme_pkg::DATA_W-1:0] dividend,
   input  logic [sme_pkg::DATA_W-1:0] divisor,
   output logic                      done,
   output logic [sme_pkg::DATA_W-1:0] quotient,
   output logic [sme_pkg::DATA_W-1:0] remainder
);
   import sme_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [DATA_W-1:0] den_ff;
   logic              neg_q_ff;
   logic              neg_r_ff;

   logic [DATA_W:0]   rem_shift;
   logic [DATA_W:0]   diff;
   logic [DATA_W-1:0] mag_a;
   logic [DATA_W-1:0] mag_b;

   // magnitudes as unsigned; the most negative value maps onto itself
   assign mag_a     = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
   assign mag_b     = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
   assign rem_shift = {rem_ff, quo_ff[DATA_W-1]};
   assign diff      = rem_shift - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(DATA_W - 1);
            rem_ff   <= '0;
            quo_ff   <= mag_a;
            den_ff   <= mag_b;
            neg_q_ff <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            neg_r_ff <= dividend[DATA_W-1];
         end else if (busy_ff) begin
            if (!diff[DATA_W]) begin
               rem_ff <= diff[DATA_W-1:0];
               quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_shift[DATA_W-1:0];
               quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
            end
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign remainder = neg_r_ff ? (~rem_ff + 1'b1) : rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done longer than one cycle");
endmodule
